/* rtl/cmfr_pkg.sv */
package cmfr_pkg;

  // identifier field positions
  localparam int unsigned DestLsb = 21;
  localparam int unsigned SrcLsb  = 13;
  localparam int unsigned KindLsb = 5;

  // frame layout
  localparam int unsigned HdrBytes = 3;
  localparam int unsigned ChunkMax = 5;
  localparam logic [3:0]  MaxDlc   = 4'd8;
  localparam logic [3:0]  HdrDlc   = 4'd3;
  localparam logic [7:0]  FlagSet  = 8'd1;

  // per-node counter widths
  localparam int unsigned CntW  = 7;
  localparam int unsigned ExpW  = 8;
  localparam int unsigned MetaW = CntW + ExpW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_EVAL,
    ST_WRITE,
    ST_EMIT_RD,
    ST_EMIT_LD
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic load_frame;
    logic meta_rd;
    logic eval;
    logic wr_byte;
    logic pay_rd;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic ok;
    logic chunk_zero;
    logic is_end;
    logic wr_last;
    logic emit_last;
    logic out_free;
  } status_t;

endpackage

/* rtl/cmfr_ctrl.sv */
module cmfr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  cmfr_pkg::status_t status_i,
  output cmfr_pkg::cmd_t    cmd_o
);

  cmfr_pkg::ctrl_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cmfr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      cmfr_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_frame = 1'b1;
          state_d          = cmfr_pkg::ST_LOOKUP;
        end
      end
      cmfr_pkg::ST_LOOKUP: begin
        cmd_o.meta_rd = 1'b1;
        state_d       = cmfr_pkg::ST_EVAL;
      end
      cmfr_pkg::ST_EVAL: begin
        cmd_o.eval = 1'b1;
        if (!status_i.ok) begin
          state_d = cmfr_pkg::ST_IDLE;
        end else if (!status_i.chunk_zero) begin
          state_d = cmfr_pkg::ST_WRITE;
        end else if (status_i.is_end) begin
          state_d = cmfr_pkg::ST_EMIT_RD;
        end else begin
          state_d = cmfr_pkg::ST_IDLE;
        end
      end
      cmfr_pkg::ST_WRITE: begin
        cmd_o.wr_byte = 1'b1;
        if (status_i.wr_last) begin
          state_d = status_i.is_end ? cmfr_pkg::ST_EMIT_RD : cmfr_pkg::ST_IDLE;
        end
      end
      cmfr_pkg::ST_EMIT_RD: begin
        cmd_o.pay_rd = 1'b1;
        state_d      = cmfr_pkg::ST_EMIT_LD;
      end
      cmfr_pkg::ST_EMIT_LD: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = status_i.emit_last ? cmfr_pkg::ST_IDLE : cmfr_pkg::ST_EMIT_RD;
        end
      end
      default: begin
        state_d = cmfr_pkg::ST_IDLE;
      end
    endcase
  end

  // an accepted word always starts a lookup
  a_accept_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == cmfr_pkg::ST_LOOKUP)
    else $error("accepted word did not start a lookup");

  // a word is loaded into the output register only from the emit state
  a_load_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> state_q == cmfr_pkg::ST_EMIT_LD && status_i.out_free)
    else $error("output load outside emit state");

  // emission always follows a read of the payload store
  a_emit_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == cmfr_pkg::ST_EMIT_LD && $past(state_q) != cmfr_pkg::ST_EMIT_LD |->
      $past(state_q) == cmfr_pkg::ST_EMIT_RD)
    else $error("emit state entered without a payload read");

endmodule

/* rtl/cmfr_dpath.sv */
module cmfr_dpath #(
  parameter int unsigned BUFFER_BYTES = 64,
  parameter int unsigned NODE_COUNT   = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmfr_pkg::cmd_t    cmd_i,
  output cmfr_pkg::status_t status_o,
  input  logic [28:0]       frame_id_i,
  input  logic [3:0]        byte_count_i,
  input  logic [7:0]        payload_0_i,
  input  logic [7:0]        payload_1_i,
  input  logic [7:0]        payload_2_i,
  input  logic [7:0]        payload_3_i,
  input  logic [7:0]        payload_4_i,
  input  logic [7:0]        payload_5_i,
  input  logic [7:0]        payload_6_i,
  input  logic [7:0]        payload_7_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        source_node_o,
  output logic [7:0]        dest_node_o,
  output logic [7:0]        message_kind_o,
  output logic [6:0]        message_length_o,
  output logic [5:0]        byte_offset_o,
  output logic [7:0]        data_byte_o,
  output logic              byte_valid_o,
  output logic              last_o
);

  localparam int unsigned NodeW  = $clog2(NODE_COUNT);
  localparam int unsigned OffW   = $clog2(BUFFER_BYTES);
  localparam int unsigned PayD   = NODE_COUNT * BUFFER_BYTES;
  localparam int unsigned PayAw  = $clog2(PayD);
  localparam int unsigned CntW   = cmfr_pkg::CntW;
  localparam int unsigned ExpW   = cmfr_pkg::ExpW;

  // latched frame
  logic [28:0] id_q;
  logic [3:0]  dlc_q;
  logic [7:0]  idx_q;
  logic        start_q;
  logic        end_q;
  logic [7:0]  data_q [cmfr_pkg::ChunkMax];

  // per-node counters, valid bits give the zero reset value
  logic [cmfr_pkg::MetaW-1:0] meta_mem [NODE_COUNT];
  logic [NODE_COUNT-1:0]      cnt_vld_q;
  logic [cmfr_pkg::MetaW-1:0] meta_rd_q;
  logic                       meta_vld_q;

  // payload store
  logic [7:0] pay_mem [PayD];
  logic [7:0] pay_rd_q;

  // working counters
  logic [CntW-1:0] cur_have_q;
  logic [CntW-1:0] have_q;
  logic [2:0]      j_q;
  logic [OffW-1:0] i_q;

  // output register
  logic            out_valid_q;
  logic [7:0]      src_out_q, dest_out_q, kind_out_q, data_out_q;
  logic [6:0]      len_out_q;
  logic [5:0]      off_out_q;
  logic            bval_out_q, last_out_q;

  logic [7:0]       src_f;
  logic [NodeW-1:0] node_idx;
  logic [3:0]       dlc_c;
  logic [2:0]       chunk_len;
  logic             drop;
  logic [CntW-1:0]  rd_have, cur_have;
  logic [ExpW-1:0]  rd_exp, cur_exp;
  logic [7:0]       have_sum;
  logic             match, fits, ok;
  logic [CntW-1:0]  wr_sum;
  logic [PayAw-1:0] node_base, wr_addr, rd_addr;
  logic             out_free;

  // frame capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_frame) begin
      id_q      <= frame_id_i;
      dlc_q     <= byte_count_i;
      idx_q     <= payload_0_i;
      start_q   <= payload_1_i == cmfr_pkg::FlagSet;
      end_q     <= payload_2_i == cmfr_pkg::FlagSet;
      data_q[0] <= payload_3_i;
      data_q[1] <= payload_4_i;
      data_q[2] <= payload_5_i;
      data_q[3] <= payload_6_i;
      data_q[4] <= payload_7_i;
    end
  end

  // frame decode
  assign src_f     = id_q[cmfr_pkg::SrcLsb +: 8];
  assign node_idx  = src_f[NodeW-1:0];
  assign dlc_c     = (dlc_q > cmfr_pkg::MaxDlc) ? cmfr_pkg::MaxDlc : dlc_q;
  assign chunk_len = 3'(dlc_c - cmfr_pkg::HdrDlc);
  assign drop      = (dlc_q < cmfr_pkg::HdrDlc) || (32'(src_f) >= NODE_COUNT);

  // chunk check against the node's counters
  assign rd_have  = meta_rd_q[CntW-1:0];
  assign rd_exp   = meta_rd_q[cmfr_pkg::MetaW-1:CntW];
  assign cur_have = (meta_vld_q && !start_q) ? rd_have : '0;
  assign cur_exp  = (meta_vld_q && !start_q) ? rd_exp : '0;
  assign have_sum = {1'b0, cur_have} + 8'(chunk_len);
  assign match    = idx_q == cur_exp;
  assign fits     = have_sum <= 8'(BUFFER_BYTES);
  assign ok       = !drop && match && fits;

  // counter memory read
  always_ff @(posedge clk_i) begin
    if (cmd_i.meta_rd) begin
      meta_rd_q  <= meta_mem[node_idx];
      meta_vld_q <= cnt_vld_q[node_idx];
    end
  end

  // counter memory write, start clears even when the chunk is refused
  always_ff @(posedge clk_i) begin
    if (cmd_i.eval && !drop && (start_q || ok)) begin
      meta_mem[node_idx] <= ok ? {cur_exp + 8'd1, have_sum[CntW-1:0]} : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q <= '0;
    end else if (cmd_i.eval && !drop && (start_q || ok)) begin
      cnt_vld_q[node_idx] <= 1'b1;
    end
  end

  // working counters
  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      cur_have_q <= cur_have;
      have_q     <= have_sum[CntW-1:0];
      j_q        <= '0;
      i_q        <= '0;
    end else begin
      if (cmd_i.wr_byte) begin
        j_q <= j_q + 3'd1;
      end
      if (cmd_i.out_load) begin
        i_q <= i_q + OffW'(1);
      end
    end
  end

  // payload store addressing
  assign wr_sum    = cur_have_q + CntW'(j_q);
  assign node_base = PayAw'(node_idx) * PayAw'(BUFFER_BYTES);
  assign wr_addr   = node_base + PayAw'(wr_sum[OffW-1:0]);
  assign rd_addr   = node_base + PayAw'(i_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_byte) begin
      pay_mem[wr_addr] <= data_q[j_q];
    end
    if (cmd_i.pay_rd) begin
      pay_rd_q <= pay_mem[rd_addr];
    end
  end

  // output register
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      src_out_q  <= src_f;
      dest_out_q <= id_q[cmfr_pkg::DestLsb +: 8];
      kind_out_q <= id_q[cmfr_pkg::KindLsb +: 8];
      len_out_q  <= have_q;
      off_out_q  <= 6'(i_q);
      data_out_q <= (have_q == '0) ? 8'd0 : pay_rd_q;
      bval_out_q <= have_q != '0;
      last_out_q <= status_o.emit_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign source_node_o    = src_out_q;
  assign dest_node_o      = dest_out_q;
  assign message_kind_o   = kind_out_q;
  assign message_length_o = len_out_q;
  assign byte_offset_o    = off_out_q;
  assign data_byte_o      = data_out_q;
  assign byte_valid_o     = bval_out_q;
  assign last_o           = last_out_q;

  // status back to the controller
  assign status_o.ok         = ok;
  assign status_o.chunk_zero = chunk_len == 3'd0;
  assign status_o.is_end     = end_q;
  assign status_o.wr_last    = (j_q + 3'd1) == chunk_len;
  assign status_o.emit_last  = (have_q == '0) || ((CntW'(i_q) + CntW'(1)) == have_q);
  assign status_o.out_free   = out_free;

  // output register never overwritten while a word waits
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !out_valid_q || !out_stall_i)
    else $error("output word overwritten while stalled");

  // chunk writes stay inside the node's buffer
  a_wr_in_buffer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_byte |-> 32'(wr_sum) < BUFFER_BYTES)
    else $error("chunk write beyond node buffer");

  // emitted offset stays below the message length
  a_offset_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load && have_q != '0 |-> CntW'(i_q) < have_q)
    else $error("emitted offset beyond message length");

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(off_out_q) && $stable(data_out_q))
    else $error("stalled output word changed");

endmodule

/* rtl/can_multi_frame_reassembler_core.sv */
// reassembles multi-frame messages carried in extended CAN frames
//
// input channel: one received frame per word (identifier, length code and the
// eight payload bytes), taken when in_valid_i is high and in_stall_o is low.
// the identifier gives destination, source and message type; every source node
// keeps its own byte count, expected chunk and a buffer of BUFFER_BYTES bytes.
// output channel: one word per message byte when a frame with the end flag
// completes a message, or a single empty word for an empty message; taken
// when out_valid_o is high and out_stall_i is low.
//
// sequence: a frame passes through the counter lookup, then the check, then
// one write per data byte; a frame without end flag then frees the input. an
// end frame goes on to emit each message byte as a payload store read followed
// by an output register load, which waits while the output register is held;
// the input stays stalled until the last byte is loaded. the payload store has
// a single read port, so each emitted byte needs its own read.
// a stalled receiver holds the output register; the block keeps working on the
// next frame until it needs to load another result word.
// reset clears all node counters at once through per-node valid bits and
// empties the output register; the payload store is not cleared.
module can_multi_frame_reassembler_core #(
  parameter int unsigned BUFFER_BYTES = 64,
  parameter int unsigned NODE_COUNT   = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [28:0] frame_id_i,
  input  logic [3:0]  byte_count_i,
  input  logic [7:0]  payload_0_i,
  input  logic [7:0]  payload_1_i,
  input  logic [7:0]  payload_2_i,
  input  logic [7:0]  payload_3_i,
  input  logic [7:0]  payload_4_i,
  input  logic [7:0]  payload_5_i,
  input  logic [7:0]  payload_6_i,
  input  logic [7:0]  payload_7_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  source_node_o,
  output logic [7:0]  dest_node_o,
  output logic [7:0]  message_kind_o,
  output logic [6:0]  message_length_o,
  output logic [5:0]  byte_offset_o,
  output logic [7:0]  data_byte_o,
  output logic        byte_valid_o,
  output logic        last_o
);

  cmfr_pkg::cmd_t    cmd;
  cmfr_pkg::status_t status;

  // sequencing
  cmfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // counters, payload store and output register
  cmfr_dpath #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .NODE_COUNT   (NODE_COUNT)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .frame_id_i       (frame_id_i),
    .byte_count_i     (byte_count_i),
    .payload_0_i      (payload_0_i),
    .payload_1_i      (payload_1_i),
    .payload_2_i      (payload_2_i),
    .payload_3_i      (payload_3_i),
    .payload_4_i      (payload_4_i),
    .payload_5_i      (payload_5_i),
    .payload_6_i      (payload_6_i),
    .payload_7_i      (payload_7_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .source_node_o    (source_node_o),
    .dest_node_o      (dest_node_o),
    .message_kind_o   (message_kind_o),
    .message_length_o (message_length_o),
    .byte_offset_o    (byte_offset_o),
    .data_byte_o      (data_byte_o),
    .byte_valid_o     (byte_valid_o),
    .last_o           (last_o)
  );

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  localparam int BufBytes  = 64;
  localparam int NodeCount = 256;

  // one received frame as the sender presents it
  typedef struct packed {
    logic [28:0]     id;
    logic [3:0]      dlc;
    logic [7:0][7:0] pl;
  } frame_t;

  // one emitted message word
  typedef struct packed {
    logic [7:0] src;
    logic [7:0] dest;
    logic [7:0] kind;
    logic [6:0] len;
    logic [5:0] off;
    logic [7:0] data;
    logic       bv;
    logic       last;
  } msg_word_t;

  // how a directed row is checked
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_EMPTY
  } chk_e;

  typedef struct {
    frame_t frm;
    chk_e   chk;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [28:0] frame_id;
  logic [3:0]  byte_count;
  logic [7:0]  pl_in [8];
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  src_o;
  logic [7:0]  dest_o;
  logic [7:0]  kind_o;
  logic [6:0]  len_o;
  logic [5:0]  off_o;
  logic [7:0]  data_o;
  logic        bv_o;
  logic        last_o;

  // shadow of the per-node reassembly state
  logic [6:0]  node_fill  [NodeCount];
  logic [7:0]  node_chunk [NodeCount];
  logic [7:0]  node_buf   [NodeCount][BufBytes];

  // stimulus bookkeeping per node
  bit          gen_open [NodeCount];
  bit          gen_long [NodeCount];
  logic [7:0]  pool [6];

  msg_word_t   pending_words [$];
  dir_row_t    dir_rows [$];
  int          err_count;
  bit          steady;

  can_multi_frame_reassembler_core #(
    .BUFFER_BYTES(BufBytes),
    .NODE_COUNT  (NodeCount)
  ) dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .frame_id_i      (frame_id),
    .byte_count_i    (byte_count),
    .payload_0_i     (pl_in[0]),
    .payload_1_i     (pl_in[1]),
    .payload_2_i     (pl_in[2]),
    .payload_3_i     (pl_in[3]),
    .payload_4_i     (pl_in[4]),
    .payload_5_i     (pl_in[5]),
    .payload_6_i     (pl_in[6]),
    .payload_7_i     (pl_in[7]),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .source_node_o   (src_o),
    .dest_node_o     (dest_o),
    .message_kind_o  (kind_o),
    .message_length_o(len_o),
    .byte_offset_o   (off_o),
    .data_byte_o     (data_o),
    .byte_valid_o    (bv_o),
    .last_o          (last_o)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

  // directed frame builder, flag bits of the identifier reuse the kind bits
  function automatic frame_t mk_frame(input logic [7:0] dest, input logic [7:0] src,
                                      input logic [7:0] kind, input logic [3:0] dlc,
                                      input logic [7:0] chunk, input logic [7:0] start_b,
                                      input logic [7:0] end_b, input logic [39:0] data);
    frame_t f;
    f.id    = {dest, src, kind, kind[4:0]};
    f.dlc   = dlc;
    f.pl[0] = chunk;
    f.pl[1] = start_b;
    f.pl[2] = end_b;
    for (int i = 0; i < 5; i++) f.pl[3+i] = data[39-8*i -: 8];
    return f;
  endfunction

  // random byte that is never the flag value
  function automatic logic [7:0] not_flag();
    logic [7:0] v;
    v = 8'($urandom);
    return (v == cmfr_pkg::FlagSet) ? 8'h00 : v;
  endfunction

  // the single word of a message with no bytes
  function automatic msg_word_t empty_word(input frame_t f);
    return '{f.id[cmfr_pkg::SrcLsb +: 8], f.id[cmfr_pkg::DestLsb +: 8],
             f.id[cmfr_pkg::KindLsb +: 8], 7'd0, 6'd0, 8'd0, 1'b0, 1'b1};
  endfunction

  // update node state for one frame, queue the message words it completes
  function automatic void reassemble_frame(input frame_t f, input bit keep);
    logic [7:0] src;
    logic [3:0] len;
    int         clen;
    int         have;
    src = f.id[cmfr_pkg::SrcLsb +: 8];
    if (f.dlc < cmfr_pkg::HdrDlc) return;
    len = (f.dlc > cmfr_pkg::MaxDlc) ? cmfr_pkg::MaxDlc : f.dlc;
    // start clears the node before the index check
    if (f.pl[1] == cmfr_pkg::FlagSet) begin
      node_fill[src]  = '0;
      node_chunk[src] = '0;
    end
    if (f.pl[0] != node_chunk[src]) return;
    clen = int'(len) - int'(cmfr_pkg::HdrBytes);
    have = int'(node_fill[src]);
    // overflow drops the frame, end flag included
    if (have + clen > BufBytes) return;
    for (int i = 0; i < clen; i++) node_buf[src][have+i] = f.pl[cmfr_pkg::HdrBytes+i];
    have += clen;
    node_fill[src]  = 7'(have);
    node_chunk[src] = node_chunk[src] + 8'd1;
    if (f.pl[2] != cmfr_pkg::FlagSet || !keep) return;
    if (have == 0) begin
      pending_words.push_back(empty_word(f));
    end else begin
      for (int i = 0; i < have; i++) begin
        pending_words.push_back('{src, f.id[cmfr_pkg::DestLsb +: 8],
                                  f.id[cmfr_pkg::KindLsb +: 8], 7'(have), 6'(i),
                                  node_buf[src][i], 1'b1, 1'(i == have - 1)});
      end
    end
  endfunction

  // shaped random frame: mostly well-formed message traffic on a few nodes
  task automatic make_frame_rand(output frame_t f);
    int         r;
    logic [7:0] node;
    bit         start;
    bit         fin;
    int         fill;
    int         clen;
    f.id  = 29'($urandom);
    f.dlc = 4'($urandom);
    for (int i = 0; i < 8; i++) f.pl[i] = 8'($urandom);
    r = $urandom_range(99);
    // noise
    if (r < 10) begin
      if ($urandom_range(3) == 0) f.pl[1] = cmfr_pkg::FlagSet;
      if ($urandom_range(3) == 0) f.pl[2] = cmfr_pkg::FlagSet;
      return;
    end
    node = pool[$urandom_range(5)];
    f.id[cmfr_pkg::SrcLsb +: 8] = node;
    start = !gen_open[node] || ($urandom_range(99) < 5);
    if (start) begin
      gen_open[node] = 1'b1;
      gen_long[node] = ($urandom_range(9) == 0);
    end
    fill = start ? 0 : int'(node_fill[node]);
    if (gen_long[node] && fill < 58) begin
      f.dlc = cmfr_pkg::MaxDlc;
    end else if ($urandom_range(9) == 0) begin
      f.dlc = 4'($urandom_range(15, 9));
    end else begin
      f.dlc = 4'($urandom_range(8, 3));
    end
    clen = int'((f.dlc > cmfr_pkg::MaxDlc) ? cmfr_pkg::MaxDlc : f.dlc) -
           int'(cmfr_pkg::HdrBytes);
    fin = $urandom_range(99) < (gen_long[node] ? ((fill >= 58) ? 60 : 1) : 30);
    f.pl[0] = start ? 8'h00 : node_chunk[node];
    f.pl[1] = start ? cmfr_pkg::FlagSet : not_flag();
    f.pl[2] = fin ? cmfr_pkg::FlagSet : not_flag();
    if (fin && fill + clen <= BufBytes) gen_open[node] = 1'b0;
    // broken sequence: wrong index or short frame
    if (r < 16) begin
      if ($urandom_range(1) == 1) begin
        f.pl[0] = f.pl[0] + 8'($urandom_range(3, 1));
      end else begin
        f.dlc = 4'($urandom_range(2));
      end
    end
  endtask

  // present one frame, wait for acceptance, then predict
  task automatic send_frame(input frame_t f, input chk_e chk);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 20) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    frame_id   = f.id;
    byte_count = f.dlc;
    for (int i = 0; i < 8; i++) pl_in[i] = f.pl[i];
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    reassemble_frame(f, chk == CHK_MODEL);
    if (chk == CHK_EMPTY) pending_words.push_back(empty_word(f));
  endtask

  // receiver stall
  always @(negedge clk) begin
    if (rst_n) out_stall = steady ? 1'b0 : ($urandom_range(99) < 20);
  end

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    msg_word_t want;
    if (out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_words.size() == 0) begin
        err_count++;
        $display("%0t: unexpected word, expected none, actual src %0h off %0h data %0h",
                 $time, src_o, off_o, data_o);
      end else begin
        want = pending_words.pop_front();
        check_field("source_node", want.src, src_o);
        check_field("dest_node", want.dest, dest_o);
        check_field("message_kind", want.kind, kind_o);
        check_field("message_length", 8'(want.len), 8'(len_o));
        check_field("byte_offset", 8'(want.off), 8'(off_o));
        check_field("data_byte", want.data, data_o);
        check_field("byte_valid", 8'(want.bv), 8'(bv_o));
        check_field("last", 8'(want.last), 8'(last_o));
      end
    end
  end

  // stimulus
  initial begin
    frame_t     f;
    logic [7:0] node;
    err_count  = 0;
    steady     = 1'b0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    out_stall  = 1'b0;
    frame_id   = '0;
    byte_count = '0;
    for (int i = 0; i < 8; i++) pl_in[i] = '0;
    for (int n = 0; n < NodeCount; n++) begin
      node_fill[n]  = '0;
      node_chunk[n] = '0;
      gen_open[n]   = 1'b0;
      gen_long[n]   = 1'b0;
      for (int b = 0; b < BufBytes; b++) node_buf[n][b] = '0;
    end
    pool[0] = 8'h00;
    pool[1] = 8'hFF;
    for (int i = 2; i < 6; i++) pool[i] = 8'($urandom);

    // directed rows
    // empty message right after reset, extreme identifier fields
    dir_rows.push_back('{mk_frame(8'hFF, 8'h00, 8'hFF, 4'd3, 8'h00, 8'h01, 8'h01, 40'h0),
                         CHK_EMPTY});
    // wrong chunk index, node 0 now expects chunk 1
    dir_rows.push_back('{mk_frame(8'h00, 8'h00, 8'h00, 4'd3, 8'h00, 8'h00, 8'h01, 40'h0),
                         CHK_NONE});
    // short frames are dropped, start clear included
    dir_rows.push_back('{mk_frame(8'h12, 8'h00, 8'h34, 4'd2, 8'h01, 8'h01, 8'h01, 40'h0),
                         CHK_NONE});
    dir_rows.push_back('{mk_frame(8'h00, 8'h10, 8'h00, 4'd0, 8'h00, 8'h01, 8'h00, 40'h0),
                         CHK_NONE});
    // two-frame message, second with a length code above 8
    dir_rows.push_back('{mk_frame(8'h01, 8'h01, 8'h02, 4'd8, 8'h00, 8'h01, 8'h00,
                                  40'hFFFFFFFFFF), CHK_NONE});
    dir_rows.push_back('{mk_frame(8'hFF, 8'h01, 8'h00, 4'd15, 8'h01, 8'h00, 8'h01,
                                  40'h0), CHK_MODEL});
    // interleaved nodes, one bad index in the middle
    dir_rows.push_back('{mk_frame(8'h33, 8'h02, 8'h44, 4'd5, 8'h00, 8'h01, 8'h00,
                                  40'h1122334455), CHK_NONE});
    dir_rows.push_back('{mk_frame(8'h00, 8'hFF, 8'hFF, 4'd4, 8'h00, 8'h01, 8'h00,
                                  40'hAABBCCDDEE), CHK_NONE});
    dir_rows.push_back('{mk_frame(8'h33, 8'h02, 8'h44, 4'd8, 8'h05, 8'h00, 8'h01,
                                  40'h5555555555), CHK_NONE});
    dir_rows.push_back('{mk_frame(8'h77, 8'h02, 8'h88, 4'd8, 8'h01, 8'h00, 8'h01,
                                  40'h6677889900), CHK_MODEL});
    // start on a wrong index still clears the node
    dir_rows.push_back('{mk_frame(8'h00, 8'hFF, 8'h00, 4'd3, 8'h01, 8'h01, 8'h01, 40'h0),
                         CHK_NONE});
    dir_rows.push_back('{mk_frame(8'hA5, 8'hFF, 8'h5A, 4'd3, 8'h00, 8'h00, 8'h01, 40'h0),
                         CHK_EMPTY});
    // flag bytes other than exactly one are not flags
    dir_rows.push_back('{mk_frame(8'h00, 8'h80, 8'h00, 4'd6, 8'h00, 8'h81, 8'h03,
                                  40'h0102030405), CHK_NONE});
    dir_rows.push_back('{mk_frame(8'h80, 8'h80, 8'h80, 4'd9, 8'h01, 8'h00, 8'h01,
                                  40'hF0E0D0C0B0), CHK_MODEL});
    // message without start, then continued after its end
    dir_rows.push_back('{mk_frame(8'h00, 8'h55, 8'h01, 4'd8, 8'h00, 8'h00, 8'h01,
                                  40'h00FF00FF80), CHK_MODEL});
    dir_rows.push_back('{mk_frame(8'h00, 8'h55, 8'h01, 4'd7, 8'h01, 8'hFF, 8'hFE,
                                  40'h7F017F0100), CHK_NONE});
    dir_rows.push_back('{mk_frame(8'h55, 8'h55, 8'hAA, 4'd3, 8'h02, 8'h00, 8'h01, 40'h0),
                         CHK_MODEL});
    dir_rows.push_back('{mk_frame(8'h00, 8'h00, 8'h00, 4'd8, 8'h01, 8'h00, 8'h01,
                                  40'h123456789A), CHK_MODEL});

    // reset
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    repeat (2) @(posedge clk);

    foreach (dir_rows[i]) send_frame(dir_rows[i].frm, dir_rows[i].chk);

    // hold the sender until every message word is out
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_words.size() != 0) @(negedge clk);

    // chunk counter wrap on one node
    node = 8'($urandom);
    f.id = 29'($urandom);
    f.id[cmfr_pkg::SrcLsb +: 8] = node;
    for (int i = 0; i <= 256; i++) begin
      for (int b = 0; b < 8; b++) f.pl[b] = 8'($urandom);
      f.pl[0] = 8'(i);
      f.pl[1] = (i == 0) ? cmfr_pkg::FlagSet : not_flag();
      f.pl[2] = (i == 256) ? cmfr_pkg::FlagSet : not_flag();
      f.dlc   = (i == 0) ? cmfr_pkg::MaxDlc :
                ((i == 256) ? 4'($urandom_range(8, 3)) : cmfr_pkg::HdrDlc);
      send_frame(f, CHK_MODEL);
    end
    gen_open[node] = 1'b0;

    // random traffic, one long stretch without idling
    for (int i = 0; i < 155; i++) begin
      steady = (i >= 60 && i < 130);
      make_frame_rand(f);
      send_frame(f, CHK_MODEL);
    end
    steady = 1'b0;
    @(negedge clk);
    in_valid = 1'b0;

    // drain
    while (pending_words.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
